FILE: hw/rtl/mket_pkg.sv
// ----------------------------------------------------------------------------
// mket_pkg: shared types for the keyed device table
// Command, status and cell operation codes, the stored entry layout and the
// record that travels down the scan chain.
// ----------------------------------------------------------------------------
package mket_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_COUNT  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_UPDATED   = 3'd0,
        STS_INSERTED  = 3'd1,
        STS_EVICTED   = 3'd2,
        STS_REMOVED   = 3'd3,
        STS_NOT_FOUND = 3'd4,
        STS_FOUND     = 3'd5,
        STS_COUNTED   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        CO_NONE   = 3'd0,
        CO_UPDATE = 3'd1,
        CO_APPEND = 3'd2,
        CO_DROP   = 3'd3,
        CO_EVICT  = 3'd4
    } t_cell_code;

    typedef struct packed {
        logic [1:0]        ty;
        logic signed [7:0] rssi;
        logic [31:0]       first_seen;
        logic [31:0]       last_seen;
        logic [7:0]        channel;
        logic [7:0]        auth_type;
        logic [15:0]       client_count;
        logic [3:0]        flags;
    } t_entry;

    // Command broadcast to every cell.
    typedef struct packed {
        t_cell_code  code;
        logic [47:0] key;
        t_entry      entry;
    } t_op;

    // Fixed-width part of the record passed from cell to cell during a scan.
    typedef struct packed {
        logic        hit;
        t_entry      entry;
        logic [31:0] min_last;
    } t_scan;

endpackage

FILE: hw/rtl/mket_cell.sv
// ----------------------------------------------------------------------------
// mket_cell: one table slot
// Holds one entry and its valid bit, folds itself into the scan record that
// passes through it every cycle, and applies the broadcast table operation.
// ----------------------------------------------------------------------------
module mket_cell #(
    parameter int DEPTH = 64,
    parameter int IDX   = 0,
    localparam int IW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mket_pkg::t_op        i_op,
    input  logic [IW-1:0]        i_sel_idx,
    input  logic                 i_prev_valid,
    input  logic                 i_next_valid,
    input  logic [47:0]          i_next_key,
    input  mket_pkg::t_entry     i_next_entry,
    output logic                 o_valid,
    output logic [47:0]          o_key,
    output mket_pkg::t_entry     o_entry,
    input  mket_pkg::t_scan      i_scan,
    input  logic [IW-1:0]        i_hit_idx,
    input  logic [IW-1:0]        i_min_idx,
    input  logic [CW-1:0]        i_cnt,
    output mket_pkg::t_scan      o_scan,
    output logic [IW-1:0]        o_hit_idx,
    output logic [IW-1:0]        o_min_idx,
    output logic [CW-1:0]        o_cnt
);
    import mket_pkg::*;

    logic          r_valid, n_valid;
    logic [47:0]   r_key, n_key;
    t_entry        r_entry, n_entry;
    t_scan         r_scan, n_scan;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [IW-1:0] r_min_idx, n_min_idx;
    logic [CW-1:0] r_cnt, n_cnt;

    logic          w_hit;
    logic          w_type_hit;
    logic          w_take_min;
    logic          w_after;
    logic [IW-1:0] w_self;
    t_entry        w_merge;

    assign w_self     = IW'(IDX);
    assign w_hit      = r_valid && (r_key == i_op.key);
    assign w_type_hit = r_valid && (r_entry.ty == i_op.entry.ty);
    assign w_take_min = (IDX == 0) || (r_entry.last_seen < i_scan.min_last);
    assign w_after    = (w_self >= i_sel_idx);

    // Scan record: keys are unique, so at most one cell claims the hit.
    always_comb begin
        n_scan          = i_scan;
        n_hit_idx       = i_hit_idx;
        n_min_idx       = i_min_idx;
        n_scan.hit      = i_scan.hit | w_hit;
        if (w_hit) begin
            n_scan.entry = r_entry;
            n_hit_idx    = w_self;
        end
        if (w_take_min) begin
            n_scan.min_last = r_entry.last_seen;
            n_min_idx       = w_self;
        end
        n_cnt = i_cnt + CW'(w_type_hit);
    end

    // Merge of a new observation into the stored entry.
    always_comb begin
        w_merge              = r_entry;
        w_merge.rssi         = i_op.entry.rssi;
        w_merge.last_seen    = i_op.entry.last_seen;
        w_merge.flags        = r_entry.flags | i_op.entry.flags;
        if (i_op.entry.channel != 8'd0) begin
            w_merge.channel = i_op.entry.channel;
        end
        if (i_op.entry.auth_type != 8'd0) begin
            w_merge.auth_type = i_op.entry.auth_type;
        end
        if (i_op.entry.client_count != 16'd0) begin
            w_merge.client_count = i_op.entry.client_count;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_entry = r_entry;
        case (i_op.code)
            CO_UPDATE: begin
                if (w_hit) begin
                    n_entry = w_merge;
                end
            end
            CO_APPEND: begin
                if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_key   = i_op.key;
                    n_entry = i_op.entry;
                end
            end
            CO_DROP: begin
                if (w_after) begin
                    n_valid = i_next_valid;
                    n_key   = i_next_key;
                    n_entry = i_next_entry;
                end
            end
            CO_EVICT: begin
                if (w_after) begin
                    if (IDX == DEPTH - 1) begin
                        n_key   = i_op.key;
                        n_entry = i_op.entry;
                    end else begin
                        n_valid = i_next_valid;
                        n_key   = i_next_key;
                        n_entry = i_next_entry;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_entry   <= n_entry;
        r_scan    <= n_scan;
        r_hit_idx <= n_hit_idx;
        r_min_idx <= n_min_idx;
        r_cnt     <= n_cnt;
    end

    assign o_valid   = r_valid;
    assign o_key     = r_key;
    assign o_entry   = r_entry;
    assign o_scan    = r_scan;
    assign o_hit_idx = r_hit_idx;
    assign o_min_idx = r_min_idx;
    assign o_cnt     = r_cnt;

endmodule

FILE: hw/rtl/mac_keyed_table_oldest_eviction_unit.sv
// ----------------------------------------------------------------------------
// mac_keyed_table_oldest_eviction_unit: address-keyed device table
// Ordered table of device entries with add-or-update, remove, lookup and
// count-by-type commands, and oldest-entry eviction when full.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the input channel (i_valid / o_stall); one transfer
// carries the command and all observation fields. Each command yields exactly
// one result transfer on the output channel (o_valid / i_stall).
// The table is a row of TABLE_DEPTH cells. After a command is taken, a scan
// record walks down the row one cell per cycle, collecting the key match,
// the oldest entry and the type count. Once it has left the last cell, the
// change is applied to the cells and the result is loaded, both in the same
// cycle. Commands are handled one at a time; o_stall is high from the
// transfer until the result is registered. The result register frees the
// command side: the next command may be taken while a result still waits.
// If the receiver stalls and a second result is ready, the unit holds it
// and applies nothing until the register empties.
// Reset empties the table (all cell valid bits clear) and drops any result.
// ----------------------------------------------------------------------------
module mac_keyed_table_oldest_eviction_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [47:0]        i_mac,
    input  logic [1:0]         i_target_type,
    input  logic signed [7:0]  i_rssi,
    input  logic [31:0]        i_first_seen,
    input  logic [31:0]        i_last_seen,
    input  logic [7:0]         i_channel,
    input  logic [7:0]         i_auth_type,
    input  logic [15:0]        i_client_count,
    input  logic [3:0]         i_flags,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [1:0]         o_found_type,
    output logic signed [7:0]  o_found_rssi,
    output logic [31:0]        o_found_first_seen,
    output logic [31:0]        o_found_last_seen,
    output logic [7:0]         o_found_channel,
    output logic [7:0]         o_found_auth_type,
    output logic [15:0]        o_found_client_count,
    output logic [3:0]         o_found_flags,
    output logic [6:0]         o_match_count,
    output logic [6:0]         o_occupancy
);
    import mket_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd;
    logic [47:0]   r_key;
    t_entry        r_entry;
    logic [IW-1:0] r_scan_cnt, n_scan_cnt;
    logic [CW-1:0] r_count, n_count;

    logic          r_out_valid;
    t_status       r_status;
    t_entry        r_found;
    logic [6:0]    r_match;
    logic [6:0]    r_occ;

    // Decision made when the scan record leaves the last cell.
    t_cell_code    w_code;
    logic [IW-1:0] w_sel;
    t_status       w_status;
    t_entry        w_found;
    logic [6:0]    w_match;
    logic          w_fire;
    logic          w_full;
    t_op           w_op;

    // Cell row wiring. Index i of the scan arrays feeds cell i.
    t_scan         w_scan    [0:TABLE_DEPTH];
    logic [IW-1:0] w_hit_idx [0:TABLE_DEPTH];
    logic [IW-1:0] w_min_idx [0:TABLE_DEPTH];
    logic [CW-1:0] w_cnt     [0:TABLE_DEPTH];
    logic          w_valid   [0:TABLE_DEPTH-1];
    logic [47:0]   w_key     [0:TABLE_DEPTH-1];
    t_entry        w_entry   [0:TABLE_DEPTH-1];

    assign w_scan[0]    = '0;
    assign w_hit_idx[0] = '0;
    assign w_min_idx[0] = '0;
    assign w_cnt[0]     = '0;

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        logic          w_prev_valid;
        logic          w_next_valid;
        logic [47:0]   w_next_key;
        t_entry        w_next_entry;

        if (gi == 0) begin : g_first
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_valid = w_valid[gi-1];
        end

        // The last cell shifts in an empty slot.
        if (gi == TABLE_DEPTH - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_key   = '0;
            assign w_next_entry = '0;
        end else begin : g_inner
            assign w_next_valid = w_valid[gi+1];
            assign w_next_key   = w_key[gi+1];
            assign w_next_entry = w_entry[gi+1];
        end

        mket_cell #(
            .DEPTH (TABLE_DEPTH),
            .IDX   (gi)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_sel_idx    (w_sel),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_key   (w_next_key),
            .i_next_entry (w_next_entry),
            .o_valid      (w_valid[gi]),
            .o_key        (w_key[gi]),
            .o_entry      (w_entry[gi]),
            .i_scan       (w_scan[gi]),
            .i_hit_idx    (w_hit_idx[gi]),
            .i_min_idx    (w_min_idx[gi]),
            .i_cnt        (w_cnt[gi]),
            .o_scan       (w_scan[gi+1]),
            .o_hit_idx    (w_hit_idx[gi+1]),
            .o_min_idx    (w_min_idx[gi+1]),
            .o_cnt        (w_cnt[gi+1])
        );
    end

    assign w_full = (r_count == CW'(TABLE_DEPTH));
    assign w_fire = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    // Decide the table change and the result once the scan is complete.
    always_comb begin
        w_code   = CO_NONE;
        w_sel    = '0;
        w_status = STS_NOT_FOUND;
        w_found  = '0;
        w_match  = '0;
        n_count  = r_count;
        case (r_cmd)
            CMD_ADD: begin
                if (w_scan[TABLE_DEPTH].hit) begin
                    w_code   = CO_UPDATE;
                    w_status = STS_UPDATED;
                end else if (w_full) begin
                    // The oldest entry goes; the new one lands at the end.
                    w_code   = CO_EVICT;
                    w_sel    = w_min_idx[TABLE_DEPTH];
                    w_status = STS_EVICTED;
                end else begin
                    w_code   = CO_APPEND;
                    w_status = STS_INSERTED;
                    n_count  = r_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_scan[TABLE_DEPTH].hit) begin
                    w_code   = CO_DROP;
                    w_sel    = w_hit_idx[TABLE_DEPTH];
                    w_status = STS_REMOVED;
                    n_count  = r_count - CW'(1);
                end
            end
            CMD_LOOKUP: begin
                if (w_scan[TABLE_DEPTH].hit) begin
                    w_status = STS_FOUND;
                    w_found  = w_scan[TABLE_DEPTH].entry;
                end
            end
            CMD_COUNT: begin
                w_status = STS_COUNTED;
                w_match  = 7'(w_cnt[TABLE_DEPTH]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_op.code  = w_fire ? w_code : CO_NONE;
        w_op.key   = r_key;
        w_op.entry = r_entry;
    end

    always_comb begin
        n_state    = r_state;
        n_scan_cnt = r_scan_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state    = ST_SCAN;
                    n_scan_cnt = '0;
                end
            end
            ST_SCAN: begin
                // Count until the record has left the last cell.
                if (r_scan_cnt == IW'(TABLE_DEPTH - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_scan_cnt = r_scan_cnt + IW'(1);
                end
            end
            ST_DONE: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_cnt <= n_scan_cnt;
        if (r_state == ST_IDLE && i_valid) begin
            r_cmd                <= t_cmd'(i_command);
            r_key                <= i_mac;
            r_entry.ty           <= i_target_type;
            r_entry.rssi         <= i_rssi;
            r_entry.first_seen   <= i_first_seen;
            r_entry.last_seen    <= i_last_seen;
            r_entry.channel      <= i_channel;
            r_entry.auth_type    <= i_auth_type;
            r_entry.client_count <= i_client_count;
            r_entry.flags        <= i_flags;
        end
        if (w_fire) begin
            r_status <= w_status;
            r_found  <= w_found;
            r_match  <= w_match;
            r_occ    <= 7'(n_count);
        end
    end

    assign o_stall              = (r_state != ST_IDLE);
    assign o_valid              = r_out_valid;
    assign o_status             = r_status;
    assign o_found_type         = r_found.ty;
    assign o_found_rssi         = r_found.rssi;
    assign o_found_first_seen   = r_found.first_seen;
    assign o_found_last_seen    = r_found.last_seen;
    assign o_found_channel      = r_found.channel;
    assign o_found_auth_type    = r_found.auth_type;
    assign o_found_client_count = r_found.client_count;
    assign o_found_flags        = r_found.flags;
    assign o_match_count        = r_match;
    assign o_occupancy          = r_occ;

endmodule
